// ===== src/assert_macros.svh =====
// assertion helpers, sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/bst_pkg.sv =====
package bst_pkg;

  localparam int POS_BITS = 16;
  localparam int POS_OUT_W = 16;
  localparam int TDATA_W = 48;
  localparam int TUSER_W = 5;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_IDENT  = 4'd1;
  localparam logic [3:0] KIND_INT    = 4'd2;
  localparam logic [3:0] KIND_STRING = 4'd3;
  localparam logic [3:0] KIND_PLUS   = 4'd4;
  localparam logic [3:0] KIND_MINUS  = 4'd5;
  localparam logic [3:0] KIND_MULT   = 4'd6;
  localparam logic [3:0] KIND_DIV    = 4'd7;
  localparam logic [3:0] KIND_EQUAL  = 4'd8;
  localparam logic [3:0] KIND_BAD    = 4'd9;
  localparam logic [3:0] KIND_UNTERM = 4'd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_EQUAL = 8'h3d;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_HALT
  } scan_mode_t;

  typedef struct packed {
    logic [3:0]           token_kind;
    logic                 has_char;
    logic [7:0]           token_char;
    logic                 token_first;
    logic                 token_last;
    logic [POS_OUT_W-1:0] line_number;
    logic [POS_OUT_W-1:0] column_number;
    logic                 last_of_run;
  } tok_res_t;

  function automatic logic [POS_OUT_W-1:0] pos_field(input logic [POS_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return ext[POS_OUT_W-1:0];
  endfunction

  function automatic tok_res_t make_res(input logic [3:0] kind, input logic has,
                                        input logic [7:0] ch, input logic first,
                                        input logic last, input logic [POS_BITS-1:0] line,
                                        input logic [POS_BITS-1:0] col);
    tok_res_t r;
    r.token_kind    = kind;
    r.has_char      = has;
    r.token_char    = has ? ch : CH_NUL;
    r.token_first   = first;
    r.token_last    = last;
    r.line_number   = pos_field(line);
    r.column_number = pos_field(col);
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ===== src/bst_core.sv =====
`include "assert_macros.svh"

module bst_core
  import bst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  output tok_res_t   res0,
  output tok_res_t   res1,
  output logic [1:0] res_cnt
);

  scan_mode_t          mode_r, mode_nxt;
  logic                esc_r, esc_nxt;
  logic                sfp_r, sfp_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;

  logic       is_nul, is_nl, is_ws, is_quote, is_bs, is_let, is_dig;
  logic       cont, idle_path, idle_emit, op_bad, adv;
  logic [3:0] op_kind, run_kind;
  tok_res_t   idle_res;

  assign is_nul   = (char_code == CH_NUL);
  assign is_nl    = (char_code == CH_NL);
  assign is_ws    = (char_code == CH_SPACE) || (char_code == CH_TAB) || is_nl;
  assign is_quote = (char_code == CH_QUOTE);
  assign is_bs    = (char_code == CH_BSL);
  assign is_let   = is_letter(char_code);
  assign is_dig   = is_digit(char_code);

  always_comb begin
    case (char_code)
      CH_PLUS:  op_kind = KIND_PLUS;
      CH_MINUS: op_kind = KIND_MINUS;
      CH_STAR:  op_kind = KIND_MULT;
      CH_SLASH: op_kind = KIND_DIV;
      CH_EQUAL: op_kind = KIND_EQUAL;
      default:  op_kind = KIND_BAD;
    endcase
  end

  assign run_kind  = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_INT;
  assign cont      = (mode_r == MODE_IDENT) ? is_let : is_dig;
  assign idle_path = (mode_r == MODE_IDLE) ||
                     (((mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER)) && !cont);
  assign idle_emit = !is_ws && !is_quote;
  assign op_bad    = !is_nul && !is_ws && !is_quote && !is_let && !is_dig &&
                     (op_kind == KIND_BAD);

  // byte handled between tokens: eof, start of ident or integer, operator or error
  always_comb begin
    if (is_nul) begin
      idle_res = make_res(KIND_EOF, 1'b0, char_code, 1'b1, 1'b1, line_r, col_r);
    end else if (is_let) begin
      idle_res = make_res(KIND_IDENT, 1'b1, char_code, 1'b1, 1'b0, line_r, col_r);
    end else if (is_dig) begin
      idle_res = make_res(KIND_INT, 1'b1, char_code, 1'b1, 1'b0, line_r, col_r);
    end else begin
      idle_res = make_res(op_kind, 1'b1, char_code, 1'b1, 1'b1, line_r, col_r);
    end
  end

  assign adv = (mode_r == MODE_STRING) ||
               (((mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER)) && cont) ||
               (idle_path && !op_bad);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    sfp_nxt  = sfp_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (step) begin
      unique case (mode_r)
        MODE_STRING: begin
          sfp_nxt = 1'b0;
          if (is_nul) begin
            mode_nxt = MODE_HALT;
          end else if (is_quote && !esc_r) begin
            mode_nxt = MODE_IDLE;
          end else begin
            esc_nxt = is_bs;
          end
        end
        MODE_IDLE, MODE_IDENT, MODE_NUMBER: begin
          if (idle_path) begin
            if (is_quote) begin
              mode_nxt = MODE_STRING;
              sfp_nxt  = 1'b1;
              esc_nxt  = 1'b0;
            end else if (is_let) begin
              mode_nxt = MODE_IDENT;
            end else if (is_dig) begin
              mode_nxt = MODE_NUMBER;
            end else if (op_bad) begin
              mode_nxt = MODE_HALT;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: mode_nxt = MODE_HALT;
      endcase
      if (adv && (mode_r != MODE_HALT)) begin
        if (is_nl) begin
          line_nxt = (line_r == POS_MAX) ? line_r : line_r + POS_BITS'(1);
          col_nxt  = '0;
        end else if (!is_nul) begin
          col_nxt = (col_r == POS_MAX) ? col_r : col_r + POS_BITS'(1);
        end
      end
    end
  end

  // results
  always_comb begin
    res0    = idle_res;
    res1    = idle_res;
    res_cnt = 2'd0;
    unique case (mode_r)
      MODE_IDLE: begin
        res_cnt = idle_emit ? 2'd1 : 2'd0;
      end
      MODE_IDENT, MODE_NUMBER: begin
        if (cont) begin
          res0    = make_res(run_kind, 1'b1, char_code, 1'b0, 1'b0, line_r, col_r);
          res_cnt = 2'd1;
        end else begin
          res0    = make_res(run_kind, 1'b0, char_code, 1'b0, 1'b1, line_r, col_r);
          res_cnt = idle_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_STRING: begin
        res_cnt = 2'd1;
        if (is_nul) begin
          res0 = make_res(KIND_UNTERM, 1'b0, char_code, 1'b1, 1'b1, line_r, col_r);
        end else if (is_quote && !esc_r) begin
          res0 = make_res(KIND_STRING, 1'b0, char_code, sfp_r, 1'b1, line_r, col_r);
        end else begin
          res0 = make_res(KIND_STRING, 1'b1, char_code, sfp_r, 1'b0, line_r, col_r);
        end
      end
      default: res_cnt = 2'd0;
    endcase
    res0.last_of_run = (res_cnt == 2'd1);
    res1.last_of_run = (res_cnt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      sfp_r  <= 1'b0;
      line_r <= POS_BITS'(1);
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      sfp_r  <= sfp_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  `ASSERT_NEVER(a_line_zero, line_r == '0, "line count reached zero")
  `ASSERT_PROP(a_nl_col, step && is_nl && (mode_r != MODE_HALT) |=> col_r == '0, "column not cleared by newline")
  `ASSERT_PROP(a_two_closes, step && (res_cnt == 2'd2) |-> res0.token_last && !res0.has_char, "second result without token close")

endmodule

// ===== src/byte_stream_tokenizer.sv =====
// byte stream tokenizer
// in channel: one source byte per beat in in_tdata[7:0]; a zero byte marks end of input
// out channel: one token result per beat; out_tlast marks the last result of an input byte
//   out_tuser holds the token kind and the has_char flag, out_tdata the character,
//   first and last marks of the token, and the saturating line and column of the byte
// a byte is held in an input register, tokenized from there and its one or two
//   results written to a three-entry result queue that drives the out channel
// a result passes through the input register and the result queue before it is offered
// throughput: one byte per cycle while out_tready is high and each byte gives at most
//   one result; a byte that gives two results (the close of an identifier or integer
//   followed by another token) stalls the next byte: the result queue has one read port
// whitespace and opening quotes between tokens and bytes after a halt give no result
// reset clears the queue and the scanner: idle between tokens, line 1, column 0
// when the receiver stalls, results wait in the queue; once it holds two or more the
//   input register stops advancing and in_tready falls, so nothing is lost
// after a bad byte or an unterminated string the block halts: bytes are still
//   accepted but give no result until reset
`include "assert_macros.svh"

module byte_stream_tokenizer
  import bst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // char_code
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // token_char, token_first, token_last, line_number,
                                         // column_number, zero fill
  output logic [TUSER_W-1:0] out_tuser,  // token_kind, has_char
  output logic               out_tlast
);

  logic       stage_v_r, stage_v_nxt;
  logic [7:0] stage_char_r;
  logic       advance, pop;

  tok_res_t   res0, res1;
  logic [1:0] res_cnt, push_cnt;

  tok_res_t   fifo_mem_r [3];
  logic [1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  tok_res_t   head;

  function automatic logic [1:0] ptr_add(input logic [1:0] p, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  assign advance     = stage_v_r && (fifo_cnt_r <= 2'd1);
  assign in_tready   = !stage_v_r || advance;
  assign stage_v_nxt = (in_tvalid && in_tready) || (stage_v_r && !advance);

  bst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (stage_char_r),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  assign push_cnt     = advance ? res_cnt : 2'd0;
  assign pop          = out_tvalid && out_tready;
  assign fifo_cnt_nxt = fifo_cnt_r + push_cnt - {1'b0, pop};
  assign rd_ptr_nxt   = pop ? ptr_add(rd_ptr_r, 2'd1) : rd_ptr_r;
  assign wr_ptr_nxt   = ptr_add(wr_ptr_r, push_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r  <= 1'b0;
      fifo_cnt_r <= 2'd0;
      rd_ptr_r   <= 2'd0;
      wr_ptr_r   <= 2'd0;
    end else begin
      stage_v_r  <= stage_v_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_char_r <= in_tdata;
    end
    if (push_cnt != 2'd0) begin
      fifo_mem_r[wr_ptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      fifo_mem_r[ptr_add(wr_ptr_r, 2'd1)] <= res1;
    end
  end

  assign head       = fifo_mem_r[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != 2'd0);
  assign out_tdata  = {(TDATA_W - 42)'(0), head.column_number, head.line_number,
                       head.token_last, head.token_first, head.token_char};
  assign out_tuser  = {head.has_char, head.token_kind};
  assign out_tlast  = head.last_of_run;

  `ASSERT_PROP(a_no_overflow, advance |-> ({1'b0, fifo_cnt_r} + {1'b0, res_cnt}) <= 3'd3, "result queue overflow")
  `ASSERT_PROP(a_ptr_gap, wr_ptr_r == ptr_add(rd_ptr_r, fifo_cnt_r), "queue pointers disagree with count")
  `ASSERT_PROP(a_pop_only, pop && (push_cnt == 2'd0) |=> fifo_cnt_r == $past(fifo_cnt_r) - 2'd1, "pop did not drain queue")

endmodule
